FILE: hw/rtl/med_pkg.sv
// package for the majority element detector
// shared constants, controller states and controller/datapath command and status types
`default_nettype none

package med_pkg;

    localparam int unsigned VALUE_W   = 8;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned BIN_DEPTH = 1 << VALUE_W;

    // item limit: smaller of the set limit and the counter range
    localparam logic [COUNT_W-1:0] ITEM_LIMIT = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 48;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;  // accept an item, launch the histogram read
        logic update;   // read-modify-write the bin, publish on last
    } dp_cmd_t;

    typedef struct packed {
        logic item_last; // held item closes the set
        logic out_free;  // output register can take a result this cycle
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/majority_element_detector.sv
// top level of the majority element detector
// joins med_controller and med_datapath; uses med_pkg
//
//  channel  | dir | tdata fields (lsb first)                               | side
//  s_       | in  | value[7:0]; tlast marks the last item of a set         | items
//  m_       | out | found[0] majority_value[8:1] occurrences[24:9]         | results
//           |     | set_size[40:25] overflowed[41] zero[47:42]             |
//
// each item is first accepted with its histogram bin read, then the bin is written
// back and the best value updated (single-port histogram memory)
// one result per set, on the last item, held in an output register
// reset (aresetn low, synchronous) clears the bin valid bits and totals at once
// a last item stalls in its update cycle only while a previous result is not taken
`default_nettype none

module majority_element_detector (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [med_pkg::S_TDATA_W-1:0]     s_tdata,   // value[7:0]
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [med_pkg::M_TDATA_W-1:0]          m_tdata    // found, majority_value,
                                                              // occurrences, set_size,
                                                              // overflowed, zero pad
);

    med_pkg::dp_cmd_t    cmd;
    med_pkg::dp_status_t status;

    med_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    med_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_value (s_tdata[med_pkg::VALUE_W-1:0]),
        .in_last  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/med_datapath.sv
// datapath of the majority element detector: histogram memory, bin valid bits,
// running totals and the result register; uses med_pkg
`default_nettype none

module med_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [med_pkg::VALUE_W-1:0]     in_value,
    input  wire logic                            in_last,
    input  wire med_pkg::dp_cmd_t                cmd,
    output med_pkg::dp_status_t                  status,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [med_pkg::M_TDATA_W-1:0]        m_tdata
);

    logic [med_pkg::COUNT_W-1:0] bin_mem [med_pkg::BIN_DEPTH];
    logic [med_pkg::COUNT_W-1:0] rdata_reg;
    logic [med_pkg::BIN_DEPTH-1:0] bin_valid_reg, bin_valid_next;

    logic [med_pkg::VALUE_W-1:0] value_reg;
    logic                        last_reg;

    logic [med_pkg::COUNT_W-1:0] total_reg, total_next;
    logic [med_pkg::COUNT_W-1:0] best_cnt_reg, best_cnt_next;
    logic [med_pkg::VALUE_W-1:0] best_val_reg, best_val_next;
    logic                        ovf_reg, ovf_next;

    logic                         out_valid_reg, out_valid_next;
    logic [med_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [med_pkg::COUNT_W-1:0] count_cur;
    logic [med_pkg::COUNT_W-1:0] count_new;
    logic                        at_limit;
    logic                        bin_write;
    logic [med_pkg::COUNT_W-1:0] total_upd;
    logic [med_pkg::COUNT_W-1:0] best_cnt_upd;
    logic [med_pkg::VALUE_W-1:0] best_val_upd;
    logic                        ovf_upd;
    logic                        found;

    // histogram memory, registered read at accept time
    always_ff @(posedge aclk) begin
        if (bin_write) begin
            bin_mem[value_reg] <= count_new;
        end
        if (cmd.capture) begin
            rdata_reg <= bin_mem[in_value];
            value_reg <= in_value;
            last_reg  <= in_last;
        end
    end

    always_comb begin
        count_cur = bin_valid_reg[value_reg] ? rdata_reg : '0;
        count_new = (count_cur != med_pkg::COUNT_MAX) ? count_cur + 1'b1 : count_cur;
        at_limit  = (total_reg == med_pkg::ITEM_LIMIT);
        bin_write = cmd.update && !at_limit;

        total_upd    = total_reg;
        best_cnt_upd = best_cnt_reg;
        best_val_upd = best_val_reg;
        ovf_upd      = ovf_reg;
        if (at_limit) begin
            ovf_upd = 1'b1;
        end else begin
            total_upd = total_reg + 1'b1;
            if (count_new > best_cnt_reg) begin
                best_cnt_upd = count_new;
                best_val_upd = value_reg;
            end
        end

        found = {best_cnt_upd, 1'b0} > {1'b0, total_upd};

        status.item_last = last_reg;
        status.out_free  = !out_valid_reg || m_tready;

        total_next     = total_reg;
        best_cnt_next  = best_cnt_reg;
        best_val_next  = best_val_reg;
        ovf_next       = ovf_reg;
        bin_valid_next = bin_valid_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        if (cmd.update) begin
            if (last_reg) begin
                // publish and clear for the next set
                out_valid_next = 1'b1;
                out_data_next  = {6'd0, ovf_upd, total_upd, best_cnt_upd, best_val_upd, found};
                total_next     = '0;
                best_cnt_next  = '0;
                best_val_next  = '0;
                ovf_next       = 1'b0;
                bin_valid_next = '0;
            end else begin
                total_next    = total_upd;
                best_cnt_next = best_cnt_upd;
                best_val_next = best_val_upd;
                ovf_next      = ovf_upd;
                if (bin_write) begin
                    bin_valid_next[value_reg] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            best_cnt_reg  <= '0;
            best_val_reg  <= '0;
            ovf_reg       <= 1'b0;
            bin_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            total_reg     <= total_next;
            best_cnt_reg  <= best_cnt_next;
            best_val_reg  <= best_val_next;
            ovf_reg       <= ovf_next;
            bin_valid_reg <= bin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/med_controller.sv
// controller state machine of the majority element detector
// sequences accept and histogram update; uses med_pkg
`default_nettype none

module med_controller (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire med_pkg::dp_status_t status,
    output med_pkg::dp_cmd_t         cmd
);

    med_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= med_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.update  = 1'b0;
        unique case (state_reg)
            med_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = med_pkg::ST_UPDATE;
                end
            end
            med_pkg::ST_UPDATE: begin
                // a closing item waits for room in the output register
                if (!status.item_last || status.out_free) begin
                    cmd.update = 1'b1;
                    state_next = med_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = med_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for majority_element_detector: streams value sets, predicts each
// set's verdict and compares every result transfer field by field; needs med_pkg and the rtl
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STUCK_LIMIT = 1000;  // cycles with no transfer on either side
    localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int unsigned MAX_SHOWN   = 10;

    typedef struct packed {
        logic                          found;
        logic [med_pkg::VALUE_W-1:0]   value;
        logic [med_pkg::COUNT_W-1:0]   occ;
        logic [med_pkg::COUNT_W-1:0]   size;
        logic                          ovf;
    } verdict_t;

    typedef struct {
        logic [7:0]  value;
        logic        last;
        int unsigned gap;   // idle cycles before this item is offered
    } item_t;

    typedef enum int { SET_DOMINANT, SET_FEW, SET_SCATTERED } set_shape_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [med_pkg::S_TDATA_W-1:0] s_tdata = '0;   // value[7:0]
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [med_pkg::M_TDATA_W-1:0] m_tdata;        // found, majority_value[8:1],
                                                   // occurrences[24:9], set_size[40:25],
                                                   // overflowed[41], zero pad

    majority_element_detector i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // histogram mirror
    logic [med_pkg::COUNT_W-1:0] bin_cnt [med_pkg::BIN_DEPTH];
    logic                        bin_seen [med_pkg::BIN_DEPTH];
    logic [med_pkg::COUNT_W-1:0] set_total;
    logic [med_pkg::COUNT_W-1:0] lead_count;
    logic [med_pkg::VALUE_W-1:0] lead_value;
    logic                        clipped;

    verdict_t    due_verdicts [$];
    item_t       pending_items [$];
    int unsigned mismatches = 0;
    int unsigned sets_checked = 0;
    int unsigned verdicts_taken = 0;   // updated nonblocking, read by the hold-off process
    int unsigned stuck_cycles = 0;
    int unsigned gap_done = 0;
    int unsigned rx_wait = 0;
    int unsigned hold_left = 0;
    logic        hold_used = 1'b0;
    logic        rx_calm = 1'b0;
    logic        s_took = 1'b0;

    function automatic void clear_histogram();
        foreach (bin_cnt[i]) begin
            bin_cnt[i]  = '0;
            bin_seen[i] = 1'b0;
        end
        set_total  = '0;
        lead_count = '0;
        lead_value = '0;
        clipped    = 1'b0;
    endfunction

    // one accepted item; on the last one the set verdict is queued
    function automatic void tally_item(input logic [7:0] v, input logic is_last);
        verdict_t                  r;
        logic [med_pkg::COUNT_W:0] c;
        if (set_total >= med_pkg::ITEM_LIMIT) begin
            clipped = 1'b1;
        end else begin
            set_total = set_total + 1'b1;
            // every 8-bit value has a bin here
            c = bin_seen[v] ? {1'b0, bin_cnt[v]} : '0;
            if (c < med_pkg::COUNT_MAX)
                c = c + 1'b1;
            bin_cnt[v]  = c[med_pkg::COUNT_W-1:0];
            bin_seen[v] = 1'b1;
            // ties keep the value that got there first
            if (c[med_pkg::COUNT_W-1:0] > lead_count) begin
                lead_count = c[med_pkg::COUNT_W-1:0];
                lead_value = v;
            end
        end
        if (is_last) begin
            r.found = ({lead_count, 1'b0} > {1'b0, set_total});
            r.value = lead_value;
            r.occ   = lead_count;
            r.size  = set_total;
            r.ovf   = clipped;
            due_verdicts.push_back(r);
            clear_histogram();
        end
    endfunction

    function automatic string show(input verdict_t r);
        return $sformatf("found=%0d value=%0d count=%0d size=%0d ovf=%0d",
                         r.found, r.value, r.occ, r.size, r.ovf);
    endfunction

    function automatic void flag_error(input string msg);
        if (mismatches < MAX_SHOWN)
            $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endfunction

    function automatic void push_item(input logic [7:0] v, input logic is_last,
                                      input int unsigned gap);
        item_t it;
        it.value = v;
        it.last  = is_last;
        it.gap   = gap;
        pending_items.push_back(it);
    endfunction

    // input side: prediction on every accepted transfer
    always @(posedge aclk) begin
        s_took = aresetn && s_tvalid && s_tready;
        if (s_took)
            tally_item(s_tdata, s_tlast);
    end

    // sender
    always @(negedge aclk) begin
        item_t it;
        if (!(s_tvalid && !s_took)) begin
            if (aresetn && pending_items.size() != 0 && gap_done >= pending_items[0].gap) begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.value;
                s_tlast  <= it.last;
                gap_done = 0;
            end else begin
                s_tvalid <= 1'b0;
                if (aresetn && pending_items.size() != 0)
                    gap_done++;
            end
        end
    end

    // long hold-off once enough verdicts have come through
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && verdicts_taken == 40) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // receiver: stall counted only while a result is offered
    always @(negedge aclk) begin
        int unsigned w;
        w = rx_wait;
        if (aresetn && m_tvalid && m_tready) begin
            if ($urandom_range(0, 7) == 0)
                rx_calm = !rx_calm;
            w = rx_calm ? 0 : $urandom_range(0, 4);
        end
        if (!aresetn || hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (w != 0) begin
            m_tready <= 1'b0;
            if (m_tvalid === 1'b1 && !m_tready)
                w--;
        end else begin
            m_tready <= 1'b1;
        end
        rx_wait = w;
    end

    // result checker
    always @(posedge aclk) begin
        verdict_t got, want;
        string    diff;
        if (aresetn && m_tvalid && m_tready) begin
            got.found = m_tdata[0];
            got.value = m_tdata[8:1];
            got.occ   = m_tdata[24:9];
            got.size  = m_tdata[40:25];
            got.ovf   = m_tdata[41];
            verdicts_taken <= verdicts_taken + 1;
            if (due_verdicts.size() == 0) begin
                flag_error({"result with none expected: ", show(got)});
            end else begin
                want = due_verdicts.pop_front();
                diff = "";
                if (got.found !== want.found) diff = {diff, " found"};
                if (got.value !== want.value) diff = {diff, " majority_value"};
                if (got.occ   !== want.occ)   diff = {diff, " occurrences"};
                if (got.size  !== want.size)  diff = {diff, " set_size"};
                if (got.ovf   !== want.ovf)   diff = {diff, " overflowed"};
                if (diff != "")
                    flag_error($sformatf("set %0d wrong:%s; expected %s, got %s",
                                         sets_checked, diff, show(want), show(got)));
            end
            sets_checked++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int unsigned n, queued, r;
        logic [7:0]  lead, v;
        logic        calm;
        set_shape_t  shape;

        clear_histogram();

        // directed sets: single items at both extremes, two-way tie, late leader,
        // exact half, clear majorities
        push_item(8'h00, 1'b1, $urandom_range(0, 4));
        push_item(8'hFF, 1'b1, $urandom_range(0, 4));
        push_item(8'd7, 1'b0, 0);
        push_item(8'd9, 1'b1, 0);
        push_item(8'd3, 1'b0, $urandom_range(0, 4));
        push_item(8'd5, 1'b0, $urandom_range(0, 4));
        push_item(8'd5, 1'b0, $urandom_range(0, 4));
        push_item(8'd3, 1'b1, $urandom_range(0, 4));
        push_item(8'd1, 1'b0, 0);
        push_item(8'd1, 1'b0, 0);
        push_item(8'd2, 1'b0, 0);
        push_item(8'd2, 1'b1, 0);
        push_item(8'h80, 1'b0, 1);
        push_item(8'h80, 1'b0, 2);
        push_item(8'h01, 1'b1, 3);
        push_item(8'hAA, 1'b0, 0);
        push_item(8'h55, 1'b0, 4);
        push_item(8'hAA, 1'b0, 0);
        push_item(8'h55, 1'b0, 1);
        push_item(8'hAA, 1'b1, 0);

        // random sets, mostly small, about half with a likely majority
        queued = 0;
        calm = 1'b0;
        while (queued < 730) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            r = $urandom_range(0, 3);
            shape = (r < 2) ? SET_DOMINANT : (r == 2) ? SET_FEW : SET_SCATTERED;
            lead = 8'($urandom);
            if ($urandom_range(0, 3) == 0)
                calm = !calm;
            for (int unsigned i = 0; i < n; i++) begin
                case (shape)
                    SET_DOMINANT: v = ($urandom_range(0, 9) < 6) ? lead : 8'($urandom);
                    SET_FEW:      v = lead ^ 8'($urandom_range(0, 2));
                    default:      v = 8'($urandom);
                endcase
                push_item(v, i == n - 1, calm ? 0 : $urandom_range(0, 4));
            end
            queued += n;
        end

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        wait (pending_items.size() == 0 && !s_tvalid);
        wait (due_verdicts.size() == 0);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && due_verdicts.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
